[hdl/chkh_pkg.sv]
// Package for the character code to keyboard report converter.
// Holds the report constants, the queue entry type and the front state type.
// No dependencies; used by every module of the block.
`default_nettype none

package chkh_pkg;

    localparam int unsigned NUM_DIGITS  = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] MOD_NONE  = 8'h00;
    localparam logic [7:0] MOD_SHIFT = 8'h20;
    localparam logic [7:0] MOD_ALT   = 8'h40;
    localparam logic [7:0] KEY_NONE  = 8'd0;
    localparam logic [7:0] KEY_ZERO  = 8'd98;
    localparam logic [7:0] KEY_BASE  = 8'd88;
    localparam logic [6:0] KEY_MASK  = 7'b1111111;

    // Reciprocal of ten: (v * RECIP_10) >> RECIP_SHIFT equals v / 10 for any 16-bit v.
    localparam logic [16:0] RECIP_10    = 17'd52429;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [3:0] STEP_FIRST       = 4'd0;
    localparam logic [3:0] STEP_DIRECT_LAST = 4'd1;
    localparam logic [3:0] STEP_DIGIT_LAST  = 4'd10;
    localparam logic [3:0] STEP_ALT_LAST    = 4'd11;

    typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

    typedef struct packed {
        logic       is_alt;
        logic [7:0] low_byte;
        digit_vec_t digits;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SPLIT,
        FR_HOLD
    } front_state_t;

endpackage

`default_nettype wire

[hdl/chkh_front.sv]
// Front part: accepts character codes, drops zero codes and classifies the rest.
// Alt codes are split into decimal digits, one digit a cycle. Uses chkh_pkg.
`default_nettype none

module chkh_front
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,
    input  wire chkh_pkg::queue_status_t q_status,
    output logic                        push,
    output chkh_pkg::entry_t            push_entry
);

    localparam logic [1:0] LAST_CNT = 2'd3;
    localparam logic [2:0] LOW_IDX  = 3'(chkh_pkg::NUM_DIGITS - 1);

    chkh_pkg::front_state_t state_reg, state_next;
    logic [1:0]             cnt_reg;
    logic [15:0]            v_reg;
    chkh_pkg::digit_vec_t   digits_reg;

    logic        s_accept;
    logic        code_high;
    logic [32:0] prod;
    logic [15:0] quot;
    logic [15:0] ten_quot;
    logic [15:0] rem_full;
    logic [2:0]  wr_idx;

    assign s_accept  = s_tvalid && s_tready;
    assign code_high = (s_tdata[15:8] != 8'd0);

    assign prod     = 33'(v_reg) * 33'(chkh_pkg::RECIP_10);
    assign quot     = 16'(prod[32:chkh_pkg::RECIP_SHIFT]);
    assign ten_quot = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
    assign rem_full = v_reg - ten_quot;
    assign wr_idx   = LOW_IDX - {1'b0, cnt_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chkh_pkg::FR_IDLE:
            begin
                if (s_accept && code_high)
                begin
                    state_next = chkh_pkg::FR_SPLIT;
                end
            end
            chkh_pkg::FR_SPLIT:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = chkh_pkg::FR_HOLD;
                end
            end
            chkh_pkg::FR_HOLD:
            begin
                if (!q_status.full)
                begin
                    state_next = chkh_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = chkh_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready            = 1'b0;
        push                = 1'b0;
        push_entry.is_alt   = 1'b0;
        push_entry.low_byte = s_tdata[7:0];
        push_entry.digits   = digits_reg;
        case (state_reg)
            chkh_pkg::FR_IDLE:
            begin
                s_tready = !q_status.full;
                push     = s_accept && !code_high && (s_tdata[7:0] != 8'd0);
            end
            chkh_pkg::FR_HOLD:
            begin
                push                 = !q_status.full;
                push_entry.is_alt    = 1'b1;
                push_entry.digits[0] = v_reg[3:0];
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chkh_pkg::FR_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == chkh_pkg::FR_SPLIT)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else
            begin
                cnt_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            v_reg <= s_tdata;
        end
        else if (state_reg == chkh_pkg::FR_SPLIT)
        begin
            v_reg              <= quot;
            digits_reg[wr_idx] <= rem_full[3:0];
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == chkh_pkg::FR_IDLE))
        else $error("front ready outside idle");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("front pushed into a full queue");

    a_split_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chkh_pkg::FR_SPLIT && cnt_reg == LAST_CNT)
        |=> (state_reg == chkh_pkg::FR_HOLD))
        else $error("digit split did not end after four steps");

    a_leading_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chkh_pkg::FR_HOLD) |-> (v_reg <= 16'd6))
        else $error("leading digit out of range");

endmodule

`default_nettype wire

[hdl/chkh_queue.sv]
// Short first-in first-out queue of classified items between front and back.
// Register array with read and write pointers. Uses chkh_pkg.
`default_nettype none

module chkh_queue
#(
    parameter int unsigned DEPTH = chkh_pkg::QUEUE_DEPTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire chkh_pkg::entry_t        push_entry,
    input  wire logic                    pop,
    output chkh_pkg::entry_t             head,
    output chkh_pkg::queue_status_t      status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    chkh_pkg::entry_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill count overflow");

    a_pointers_match: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[hdl/chkh_back.sv]
// Back part: walks the report sequence of the item at the queue head.
// Drives the output register of the result stream. Uses chkh_pkg.
`default_nettype none

module chkh_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire chkh_pkg::entry_t        head,
    input  wire chkh_pkg::queue_status_t q_status,
    output logic                         pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [15:0]                  m_tdata,
    output logic                         m_tlast
);

    logic [3:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] mod_reg, mod_next;
    logic [7:0] key_reg, key_next;
    logic       last_reg, last_next;
    logic       load;
    logic [3:0] digit;
    logic [7:0] digit_key;

    assign load      = !valid_reg || m_tready;
    assign digit     = head.digits[step_reg[3:1]];
    assign digit_key = (digit == 4'd0) ? chkh_pkg::KEY_ZERO
                                       : 8'(digit) + chkh_pkg::KEY_BASE;

    always_comb
    begin
        mod_next  = chkh_pkg::MOD_NONE;
        key_next  = chkh_pkg::KEY_NONE;
        last_next = 1'b0;
        if (head.is_alt)
        begin
            if (step_reg == chkh_pkg::STEP_ALT_LAST)
            begin
                last_next = 1'b1;
            end
            else
            begin
                mod_next = chkh_pkg::MOD_ALT;
                if (step_reg[0])
                begin
                    key_next = digit_key;
                end
            end
        end
        else
        begin
            if (step_reg == chkh_pkg::STEP_FIRST)
            begin
                mod_next = head.low_byte[7] ? chkh_pkg::MOD_SHIFT : chkh_pkg::MOD_NONE;
                key_next = {1'b0, head.low_byte[6:0] & chkh_pkg::KEY_MASK};
            end
            else
            begin
                last_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                pop       = last_next;
                step_next = last_next ? chkh_pkg::STEP_FIRST : step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= chkh_pkg::STEP_FIRST;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mod_reg  <= mod_next;
            key_reg  <= key_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {key_reg, mod_reg};
    assign m_tlast  = last_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= chkh_pkg::STEP_ALT_LAST)
        else $error("report step out of range");

    a_direct_short: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && !head.is_alt) |-> (step_reg <= chkh_pkg::STEP_DIRECT_LAST))
        else $error("direct key run longer than two reports");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == chkh_pkg::STEP_FIRST))
        else $error("step not cleared after the last report");

    a_pop_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && last_reg))
        else $error("queue pop without a final report");

endmodule

`default_nettype wire

[hdl/char_code_to_hid_keystrokes.sv]
// Top level of the character code to keyboard report converter.
// Instantiates chkh_front, chkh_queue and chkh_back; uses chkh_pkg.
//
//  Channel | Direction | Signals                       | Contents
//  s       | in        | s_tvalid s_tready s_tdata     | char_code
//  m       | out       | m_tvalid m_tready m_tdata m_tlast | modifier_byte, key_code, last_report
//
// A direct key gives two reports, an alt code twelve, one report a cycle from the output
// register while m_tready is high; the single result channel therefore sets the sustained rate.
// The front splits an alt code into digits, one reciprocal multiply a cycle, then hands it
// to the queue once there is room and takes no new code until it is back in idle.
// A zero code is accepted and gives no reports. Reset is asynchronous and needs
// no clearing pass. The queue lets the front take new items while the output is stalled.
`default_nettype none

module char_code_to_hid_keystrokes
#(
    parameter int unsigned QUEUE_DEPTH = chkh_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] char_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] modifier_byte, [15:8] key_code
    output logic             m_tlast
);

    chkh_pkg::queue_status_t q_status;
    chkh_pkg::entry_t        push_entry;
    chkh_pkg::entry_t        head;
    logic                    push;
    logic                    pop;

    chkh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    chkh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    chkh_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[dv/tb_char_code_to_hid_keystrokes.sv]
`timescale 1ns / 1ps
// Self-checking testbench for char_code_to_hid_keystrokes: drives character codes as items and
// checks every keyboard report against an in-bench prediction, with random stalls on both sides.
// Depends on chkh_pkg and the RTL of char_code_to_hid_keystrokes only.

module tb_char_code_to_hid_keystrokes;

    typedef struct packed {
        logic [7:0] modifier;
        logic [7:0] key;
        logic       last;
    } hid_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    hid_report_t expected_reports[$];
    int unsigned mismatch_count = 0;
    int unsigned report_count = 0;
    bit          idle_enable = 1'b1;
    bit          hold_request = 1'b0;

    char_code_to_hid_keystrokes dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_report(input logic [7:0] modifier, input logic [7:0] key,
                                        input logic last);
        hid_report_t r;
        r.modifier = modifier;
        r.key      = key;
        r.last     = last;
        expected_reports.push_back(r);
    endfunction

    function automatic void predict_reports(input logic [15:0] code);
        logic [3:0]  digits [chkh_pkg::NUM_DIGITS];
        int unsigned v;
        int          i;
        if (code[15:8] == 8'h00)
        begin
            if (code[7:0] == 8'h00)
                return;
            push_report(code[7] ? chkh_pkg::MOD_SHIFT : chkh_pkg::MOD_NONE,
                        {1'b0, code[6:0]}, 1'b0);
            push_report(chkh_pkg::MOD_NONE, chkh_pkg::KEY_NONE, 1'b1);
            return;
        end
        v = 32'(code);
        for (i = int'(chkh_pkg::NUM_DIGITS) - 1; i > 0; i--)
        begin
            digits[i] = 4'(v % 10);
            v = v / 10;
        end
        digits[0] = 4'(v);
        push_report(chkh_pkg::MOD_ALT, chkh_pkg::KEY_NONE, 1'b0);
        for (i = 0; i < int'(chkh_pkg::NUM_DIGITS); i++)
        begin
            push_report(chkh_pkg::MOD_ALT,
                        (digits[i] == 4'd0) ? chkh_pkg::KEY_ZERO
                                            : chkh_pkg::KEY_BASE + 8'(digits[i]),
                        1'b0);
            push_report(chkh_pkg::MOD_ALT, chkh_pkg::KEY_NONE, 1'b0);
        end
        push_report(chkh_pkg::MOD_NONE, chkh_pkg::KEY_NONE, 1'b1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] report %0d: %s", $realtime, report_count, msg);
        mismatch_count++;
    endtask

    task automatic send_code(input logic [15:0] code);
        int unsigned gap;
        gap = idle_length();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (!s_tready);
        predict_reports(code);
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int unsigned gap;
        forever
        begin
            gap = idle_length();
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        hid_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("unexpected report %h/%h last %b",
                                          m_tdata[7:0], m_tdata[15:8], m_tlast));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (m_tdata[7:0] !== want.modifier)
                    report_mismatch($sformatf("modifier_byte %h, wanted %h",
                                              m_tdata[7:0], want.modifier));
                if (m_tdata[15:8] !== want.key)
                    report_mismatch($sformatf("key_code %h, wanted %h",
                                              m_tdata[15:8], want.key));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_report %b, wanted %b",
                                              m_tlast, want.last));
            end
            report_count++;
        end
    end

    task automatic test_direct_keys();
        send_code(16'h0001);
        send_code(16'h007F);
        send_code(16'h0080);
        send_code(16'h0081);
        send_code(16'h00FF);
        send_code(16'h0041);
        send_code(16'h00AA);
        send_code(16'h0055);
    endtask

    task automatic test_zero_codes();
        send_code(16'h0000);
        send_code(16'h0000);
        send_code(16'h0061);
        send_code(16'h0000);
        send_code(16'h1234);
    endtask

    task automatic test_alt_codes();
        send_code(16'h0100);
        send_code(16'hFFFF);
        send_code(16'd10000);
        send_code(16'd60000);
        send_code(16'd59999);
        send_code(16'h8000);
        send_code(16'h0101);
        send_code(16'd12345);
        send_code(16'h5555);
        send_code(16'hAAAA);
    endtask

    task automatic test_back_to_back();
        int i;
        idle_enable = 1'b0;
        for (i = 0; i < 10; i++)
            send_code(16'($urandom));
        for (i = 0; i < 6; i++)
            send_code({8'h00, 8'($urandom)});
        idle_enable = 1'b1;
    endtask

    task automatic test_output_hold();
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 8; i++)
            send_code({8'($urandom_range(1, 255)), 8'($urandom)});
    endtask

    task automatic test_random_codes();
        int          i;
        int unsigned sel;
        logic [15:0] code;
        for (i = 0; i < 53; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                code = 16'h0000;
            else if (sel < 40)
                code = {8'h00, 8'($urandom)};
            else
                code = 16'($urandom);
            send_code(code);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_direct_keys();
        test_zero_codes();
        test_alt_codes();
        test_back_to_back();
        test_output_hold();
        test_random_codes();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("char_code_to_hid_keystrokes: match");
        else
            $display("char_code_to_hid_keystrokes: mismatch");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("char_code_to_hid_keystrokes: mismatch");
        $finish;
    end

endmodule
